@@ rtl/svse_pkg.sv @@
// ----------------------------------------------------------------------------
// svse_pkg: shared types and codes for the sorted value set engine
// Request and response payloads, command and status codes, and the control
// word broadcast to the row of storage cells.
// ----------------------------------------------------------------------------
package svse_pkg;

    localparam int VAL_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 9;
    // one hit flag above the entry value
    localparam int LEAF_W   = VAL_W + 1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VAL_W-1:0]   result_value;
        logic [COUNT_W-1:0] entry_count;
        logic [VAL_W-1:0]   largest_value;
    } rsp_t;

    // control word shared by every cell
    typedef struct packed {
        logic [1:0] op;
        logic       sel_last;
    } cell_ctrl_t;

endpackage

@@ rtl/svse_cell.sv @@
// ----------------------------------------------------------------------------
// svse_cell: one storage cell of the sorted row
// Holds one entry and its valid flag, compares it with the broadcast key,
// shifts towards or away from its neighbours, and drives one selection leaf.
// ----------------------------------------------------------------------------
module svse_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  svse_pkg::cell_ctrl_t        ctrl,
    input  logic [svse_pkg::VAL_W-1:0]  key,
    input  logic [svse_pkg::VAL_W-1:0]  left_data,
    input  logic                        left_valid,
    input  logic                        left_ins,
    input  logic                        left_lb,
    input  logic [svse_pkg::VAL_W-1:0]  right_data,
    input  logic                        right_valid,
    output logic [svse_pkg::VAL_W-1:0]  data,
    output logic                        valid,
    output logic                        ins,
    output logic                        lb,
    output logic [svse_pkg::LEAF_W-1:0] leaf
);

    logic [svse_pkg::VAL_W-1:0] data_reg;
    logic [svse_pkg::VAL_W-1:0] data_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       hit;

    // at or after the insert point / the lower bound
    assign ins = !valid_reg || (data_reg > key);
    assign lb  = !valid_reg || (data_reg >= key);

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            svse_pkg::OP_INSERT:
            begin
                if (ins && !left_ins)
                begin
                    data_next  = key;
                    valid_next = 1'b1;
                end
                else if (ins)
                begin
                    data_next  = left_data;
                    valid_next = left_valid;
                end
            end
            svse_pkg::OP_ERASE:
            begin
                if (lb)
                begin
                    data_next  = right_data;
                    valid_next = right_valid;
                end
            end
            svse_pkg::OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // first entry not below the key, or the last occupied cell
    assign hit  = ctrl.sel_last ? (valid_reg && !right_valid)
                                : (valid_reg && lb && !left_lb);
    assign leaf = hit ? {1'b1, data_reg} : '0;

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

@@ rtl/svse_tree.sv @@
// ----------------------------------------------------------------------------
// svse_tree: registered OR tree over one-hot cell leaves
// At most one leaf is non-zero; the root is reached through a register at
// every tree level.
// ----------------------------------------------------------------------------
module svse_tree
#(
    parameter int LEAVES = 256
)
(
    input  logic                                     clk,
    input  logic [LEAVES-1:0][svse_pkg::LEAF_W-1:0]  leaves,
    output logic [svse_pkg::LEAF_W-1:0]              root
);

    localparam int LEVELS = $clog2(LEAVES);
    localparam int PAD    = 1 << LEVELS;

    logic [svse_pkg::LEAF_W-1:0] leaf_pad [0:PAD-1];
    logic [svse_pkg::LEAF_W-1:0] node_reg [0:PAD-2];

    genvar g;

    generate
        for (g = 0; g < PAD; g++)
        begin : g_pad
            if (g < LEAVES)
            begin : g_used
                assign leaf_pad[g] = leaves[g];
            end
            else
            begin : g_zero
                assign leaf_pad[g] = '0;
            end
        end

        // heap order: node j has children 2j+1 and 2j+2
        for (g = 0; g < PAD - 1; g++)
        begin : g_node
            if (2 * g + 1 >= PAD - 1)
            begin : g_bottom
                always_ff @(posedge clk)
                begin
                    node_reg[g] <= leaf_pad[2 * g + 1 - (PAD - 1)]
                                 | leaf_pad[2 * g + 2 - (PAD - 1)];
                end
            end
            else
            begin : g_inner
                always_ff @(posedge clk)
                begin
                    node_reg[g] <= node_reg[2 * g + 1] | node_reg[2 * g + 2];
                end
            end
        end
    endgenerate

    assign root = node_reg[0];

endmodule

@@ rtl/sorted_value_set_engine_top.sv @@
// ----------------------------------------------------------------------------
// sorted_value_set_engine_top: ascending sorted set of 32-bit values
// A row of compare-and-shift cells holds the set; a registered OR tree picks
// the lower-bound entry and, after the update, the largest entry.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries a command and a
//   value: insert, erase, lower-bound query or clear. Response channel
//   (rsp_valid / rsp_stall / rsp) returns one response per request with
//   status, query result, entry count and largest entry.
//   cfg_wr_en / cfg_wr_data write the largest accepted value; write it only
//   while the block is idle.
//   Each request passes twice through the selection tree, one pass for the
//   lower bound and one for the largest entry, with the cell update
//   between them. One request is in flight at a time and the request
//   side reopens the cycle after the response is loaded, so a new request
//   is not accepted before the last one is loaded as a response.
//   The next request may be accepted while a response still waits; a
//   stalled response holds, and the engine waits at the end of the next
//   request until that response is taken.
//   Reset empties the set and sets the largest accepted value to all ones.
// ----------------------------------------------------------------------------
module sorted_value_set_engine_top
#(
    parameter int CAPACITY = 256
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [svse_pkg::VAL_W-1:0] cfg_wr_data,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  svse_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output svse_pkg::rsp_t             rsp
);

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TREE_LAT = $clog2(CAPACITY);
    localparam int WAIT_W   = $clog2(TREE_LAT + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [WAIT_W-1:0]          wait_reg;
    logic [WAIT_W-1:0]          wait_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [svse_pkg::VAL_W-1:0] max_value_reg;
    logic [svse_pkg::CMD_W-1:0] cmd_reg;
    logic [svse_pkg::VAL_W-1:0] key_reg;
    logic                       sel_last_reg;
    logic                       sel_last_next;
    logic [svse_pkg::STAT_W-1:0] status_reg;
    logic [svse_pkg::STAT_W-1:0] status_next;
    logic [svse_pkg::VAL_W-1:0] result_reg;
    logic [svse_pkg::VAL_W-1:0] result_next;
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    svse_pkg::rsp_t             rsp_reg;
    svse_pkg::rsp_t             rsp_next;

    logic                       req_fire;
    logic                       tree_done;
    logic                       rsp_free;
    logic [1:0]                 op_sel;
    svse_pkg::cell_ctrl_t       cell_ctrl;

    logic [svse_pkg::VAL_W-1:0]  cell_data  [0:CAPACITY-1];
    logic                        cell_valid [0:CAPACITY-1];
    logic                        cell_ins   [0:CAPACITY-1];
    logic                        cell_lb    [0:CAPACITY-1];
    logic [CAPACITY-1:0][svse_pkg::LEAF_W-1:0] leaves;
    logic [svse_pkg::LEAF_W-1:0] root;
    logic                        root_hit;
    logic [svse_pkg::VAL_W-1:0]  root_data;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign tree_done = (wait_reg == WAIT_W'(TREE_LAT));
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign root_hit  = root[svse_pkg::LEAF_W-1];
    assign root_data = root[svse_pkg::VAL_W-1:0];

    assign cell_ctrl.op       = op_sel;
    assign cell_ctrl.sel_last = sel_last_reg;

    // --- cell row --------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [svse_pkg::VAL_W-1:0] l_data;
            logic                       l_valid;
            logic                       l_ins;
            logic                       l_lb;
            logic [svse_pkg::VAL_W-1:0] r_data;
            logic                       r_valid;

            if (g == 0)
            begin : g_first
                assign l_data  = '0;
                assign l_valid = 1'b0;
                assign l_ins   = 1'b0;
                assign l_lb    = 1'b0;
            end
            else
            begin : g_mid_l
                assign l_data  = cell_data[g-1];
                assign l_valid = cell_valid[g-1];
                assign l_ins   = cell_ins[g-1];
                assign l_lb    = cell_lb[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign r_data  = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_data  = cell_data[g+1];
                assign r_valid = cell_valid[g+1];
            end

            svse_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .key         (key_reg),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .left_ins    (l_ins),
                .left_lb     (l_lb),
                .right_data  (r_data),
                .right_valid (r_valid),
                .data        (cell_data[g]),
                .valid       (cell_valid[g]),
                .ins         (cell_ins[g]),
                .lb          (cell_lb[g]),
                .leaf        (leaves[g])
            );
        end
    endgenerate

    svse_tree #(.LEAVES(CAPACITY)) u_tree
    (
        .clk    (clk),
        .leaves (leaves),
        .root   (root)
    );

    // --- control ---------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        count_next     = count_reg;
        sel_last_next  = sel_last_reg;
        status_next    = status_reg;
        result_next    = result_reg;
        op_sel         = svse_pkg::OP_HOLD;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next    = S_SRCH;
                    wait_next     = '0;
                    sel_last_next = 1'b0;
                end
            end
            S_SRCH:
            begin
                if (!tree_done)
                begin
                    wait_next = wait_reg + 1'b1;
                end
                else
                begin
                    status_next = svse_pkg::ST_OK;
                    result_next = '0;
                    if (cmd_reg == svse_pkg::CMD_CLEAR)
                    begin
                        op_sel     = svse_pkg::OP_CLEAR;
                        count_next = '0;
                    end
                    else if (key_reg > max_value_reg)
                    begin
                        status_next = svse_pkg::ST_RANGE;
                    end
                    else if (cmd_reg == svse_pkg::CMD_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = svse_pkg::ST_FULL;
                        end
                        else
                        begin
                            op_sel     = svse_pkg::OP_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (cmd_reg == svse_pkg::CMD_ERASE)
                    begin
                        if (root_hit && (root_data == key_reg))
                        begin
                            op_sel     = svse_pkg::OP_ERASE;
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            status_next = svse_pkg::ST_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        if (root_hit)
                        begin
                            result_next = root_data;
                        end
                        else
                        begin
                            status_next = svse_pkg::ST_NOT_FOUND;
                        end
                    end
                    state_next    = S_LAST;
                    wait_next     = '0;
                    sel_last_next = 1'b1;
                end
            end
            S_LAST:
            begin
                if (!tree_done)
                begin
                    wait_next = wait_reg + 1'b1;
                end
                else if (rsp_free)
                begin
                    // hand over the response; the tree root is zero when empty
                    rsp_valid_next         = 1'b1;
                    rsp_next.status        = status_reg;
                    rsp_next.result_value  = result_reg;
                    rsp_next.entry_count   = svse_pkg::COUNT_W'(count_reg);
                    rsp_next.largest_value = root_data;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            sel_last_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            max_value_reg <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            count_reg     <= count_next;
            sel_last_reg  <= sel_last_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                max_value_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg <= req.cmd;
            key_reg <= req.value;
        end
        status_reg <= status_next;
        result_reg <= result_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ tb/sorted_value_set_engine_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_value_set_engine_top_tb: regression for the sorted value set engine
// Drives insert, erase, query and clear requests under random gaps and
// response stalls. Each accepted request is applied to a local copy of the
// sorted set, and every response is checked field by field against it,
// across several settings of the largest accepted value.
// ----------------------------------------------------------------------------
module sorted_value_set_engine_top_tb;

    localparam int          CAPACITY   = 256;
    localparam int          LONG_HOLD  = 300;
    localparam int          SETTLE     = 40;
    localparam int unsigned CYCLE_CAP  = 1000000;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [svse_pkg::VAL_W-1:0]    cfg_wr_data = '0;
    logic                          req_valid   = 1'b0;
    logic                          req_stall;
    svse_pkg::req_t                req         = '0;
    logic                          rsp_valid;
    logic                          rsp_stall   = 1'b0;
    svse_pkg::rsp_t                rsp;

    // local copy of the sorted set
    logic [svse_pkg::VAL_W-1:0]    set_mem [CAPACITY];
    int unsigned                   set_count  = 0;
    logic [svse_pkg::VAL_W-1:0]    max_accept = '1;

    svse_pkg::req_t      pending_req[$];
    svse_pkg::rsp_t      expected_rsp[$];
    svse_pkg::rsp_t      want;
    int unsigned         send_gap      = 0;
    int unsigned         stall_left    = 0;
    int unsigned         hold_asks     = 0;
    int unsigned         hold_seen     = 0;
    int unsigned         cycle_cnt     = 0;
    int unsigned         fail_count    = 0;

    sorted_value_set_engine_top #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

    always #5 clk = ~clk;

    // Apply one request to the local set and return the response it should give.
    function automatic svse_pkg::rsp_t apply_request(svse_pkg::req_t r);
        svse_pkg::rsp_t o;
        int unsigned    pos;
        int unsigned    i;
        o = '0;
        o.status = svse_pkg::ST_OK;
        if (r.cmd == svse_pkg::CMD_CLEAR)
            set_count = 0;
        else if (r.value > max_accept)
            o.status = svse_pkg::ST_RANGE;
        else if (r.cmd == svse_pkg::CMD_INSERT)
        begin
            if (set_count >= CAPACITY)
                o.status = svse_pkg::ST_FULL;
            else
            begin
                // insert after any equal entries
                pos = 0;
                while (pos < set_count && set_mem[pos] <= r.value)
                    pos++;
                for (i = set_count; i > pos; i--)
                    set_mem[i] = set_mem[i-1];
                set_mem[pos] = r.value;
                set_count++;
            end
        end
        else
        begin
            pos = 0;
            while (pos < set_count && set_mem[pos] < r.value)
                pos++;
            if (r.cmd == svse_pkg::CMD_ERASE)
            begin
                if (pos < set_count && set_mem[pos] == r.value)
                begin
                    for (i = pos; i + 1 < set_count; i++)
                        set_mem[i] = set_mem[i+1];
                    set_count--;
                end
                else
                    o.status = svse_pkg::ST_NOT_FOUND;
            end
            else if (pos < set_count)
                o.result_value = set_mem[pos];
            else
                o.status = svse_pkg::ST_NOT_FOUND;
        end
        o.entry_count   = svse_pkg::COUNT_W'(set_count);
        o.largest_value = (set_count != 0) ? set_mem[set_count-1] : '0;
        return o;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        if (p < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 60);
    endfunction

    function automatic svse_pkg::req_t rand_request(int unsigned ins_pct, int unsigned era_pct,
                                                    int unsigned qry_pct, int unsigned span);
        svse_pkg::req_t r;
        int unsigned    c;
        int unsigned    m;
        c = $urandom_range(0, 99);
        if (c < ins_pct)
            r.cmd = svse_pkg::CMD_INSERT;
        else if (c < ins_pct + era_pct)
            r.cmd = svse_pkg::CMD_ERASE;
        else if (c < ins_pct + era_pct + qry_pct)
            r.cmd = svse_pkg::CMD_QUERY;
        else
            r.cmd = svse_pkg::CMD_CLEAR;
        m = $urandom_range(0, 99);
        if (m < 45)
            r.value = $urandom_range(0, span);
        else if (m < 60)
            r.value = max_accept + svse_pkg::VAL_W'($urandom_range(0, 4))
                    - svse_pkg::VAL_W'(2);
        else if (m < 70)
            r.value = $urandom_range(0, 1) ? '1 : '0;
        else
            r.value = $urandom();
        return r;
    endfunction

    task automatic push_request(logic [svse_pkg::CMD_W-1:0] c,
                                logic [svse_pkg::VAL_W-1:0] v);
        svse_pkg::req_t r;
        r.cmd   = c;
        r.value = v;
        pending_req = {pending_req, r};
    endtask

    task automatic push_random(int unsigned n, int unsigned ins_pct, int unsigned era_pct,
                               int unsigned qry_pct, int unsigned span);
        for (int unsigned k = 0; k < n; k++)
            pending_req = {pending_req, rand_request(ins_pct, era_pct, qry_pct, span)};
    endtask

    // Hold until every request is sent and every response has come back.
    task automatic wait_drained();
        while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max(logic [svse_pkg::VAL_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        max_accept   = v;
    endtask

    task automatic report_mismatch(string what, logic [svse_pkg::VAL_W-1:0] got,
                                   logic [svse_pkg::VAL_W-1:0] exp_v);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_v);
        fail_count++;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_rsp = {expected_rsp, apply_request(req)};
            if (req_valid && req_stall)
            begin
                // hold the stalled request
            end
            else if (send_gap != 0)
            begin
                send_gap  <= send_gap - 1;
                req_valid <= 1'b0;
            end
            else if (pending_req.size() != 0)
            begin
                req       <= pending_req.pop_front();
                req_valid <= 1'b1;
                send_gap  <= pick_gap();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response stall generator, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_asks != hold_seen)
        begin
            hold_seen  <= hold_asks;
            stall_left <= LONG_HOLD;
            rsp_stall  <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            stall_left <= pick_gap();
            rsp_stall  <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch("unexpected response", rsp.result_value, '0);
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", svse_pkg::VAL_W'(rsp.status),
                                    svse_pkg::VAL_W'(want.status));
                if (rsp.result_value !== want.result_value)
                    report_mismatch("result_value", rsp.result_value, want.result_value);
                if (rsp.entry_count !== want.entry_count)
                    report_mismatch("entry_count", svse_pkg::VAL_W'(rsp.entry_count),
                                    svse_pkg::VAL_W'(want.entry_count));
                if (rsp.largest_value !== want.largest_value)
                    report_mismatch("largest_value", rsp.largest_value, want.largest_value);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP)
        begin
            $display("sorted_value_set_engine_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty store, duplicates, extremes, each command
        push_request(svse_pkg::CMD_QUERY,  32'h0000_0000);
        push_request(svse_pkg::CMD_ERASE,  32'h0000_0000);
        push_request(svse_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        push_request(svse_pkg::CMD_INSERT, 32'h0000_0000);
        push_request(svse_pkg::CMD_INSERT, 32'h0000_0000);
        push_request(svse_pkg::CMD_INSERT, 32'h8000_0000);
        push_request(svse_pkg::CMD_QUERY,  32'h0000_0000);
        push_request(svse_pkg::CMD_QUERY,  32'h0000_0001);
        push_request(svse_pkg::CMD_QUERY,  32'h8000_0001);
        push_request(svse_pkg::CMD_QUERY,  32'hFFFF_FFFF);
        push_request(svse_pkg::CMD_ERASE,  32'h0000_0007);
        push_request(svse_pkg::CMD_ERASE,  32'h0000_0000);
        push_request(svse_pkg::CMD_QUERY,  32'h0000_0000);
        push_request(svse_pkg::CMD_ERASE,  32'hFFFF_FFFF);
        push_request(svse_pkg::CMD_QUERY,  32'h8000_0001);
        push_request(svse_pkg::CMD_INSERT, 32'h5555_5555);
        push_request(svse_pkg::CMD_INSERT, 32'hAAAA_AAAA);
        push_request(svse_pkg::CMD_CLEAR,  32'hFFFF_FFFF);
        push_request(svse_pkg::CMD_QUERY,  32'h0000_0000);
        wait_drained();

        // out of range on every command but clear
        write_max(32'd1000);
        push_request(svse_pkg::CMD_INSERT, 32'd1001);
        push_request(svse_pkg::CMD_ERASE,  32'd1001);
        push_request(svse_pkg::CMD_QUERY,  32'hFFFF_FFFF);
        push_request(svse_pkg::CMD_INSERT, 32'd1000);
        push_request(svse_pkg::CMD_QUERY,  32'd1001);
        push_request(svse_pkg::CMD_CLEAR,  32'd5000);
        push_request(svse_pkg::CMD_INSERT, 32'd0);
        wait_drained();

        // fill past capacity under a long receiver hold-off
        write_max('1);
        push_request(svse_pkg::CMD_CLEAR, 32'd0);
        hold_asks++;
        push_random(265, 100, 0, 0, 1000);
        wait_drained();
        push_random(40, 40, 30, 30, 1000);
        wait_drained();

        write_max('0);
        push_random(200, 35, 25, 30, 3);
        wait_drained();

        write_max($urandom());
        push_random(500, 40, 25, 30, 500);
        wait_drained();

        write_max(32'd1000);
        push_random(450, 45, 25, 25, 200);
        wait_drained();

        write_max('1);
        push_random(450, 45, 25, 25, 100);
        wait_drained();

        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("sorted_value_set_engine_top regression: pass");
        else
            $display("sorted_value_set_engine_top regression: fail");
        $finish;
    end

endmodule
